// ===== design/kmd_pkg.sv =====
package kmd_pkg;

    localparam int COLUMN_W   = 5;
    localparam int ROW_BITS_W = 6;
    localparam int RELOAD_W   = 8;
    localparam int KEY_COUNT_W = 7;

    localparam logic [RELOAD_W-1:0]    RELOAD_RESET  = 8'd5;
    localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [COLUMN_W-1:0]   column;
        logic [ROW_BITS_W-1:0] row_bits;
        logic                  scan_end;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS_W-1:0]  column_state;
        logic                   settled;
        logic                   committed;
        logic                   bounce;
        logic [KEY_COUNT_W-1:0] key_count;
    } out_item_t;

endpackage

// ===== design/key_matrix_debounce.sv =====
// path: an accepted item is held in the input register, and its result is then
// written to the result register; throughput: one item per cycle unless m_ready
// holds the result register; the stores and the countdown update in between
// reset: synchronous active-low aresetn clears both stores, sets the countdown
// and the reload register to 5, and empties the input and result registers
module key_matrix_debounce #(
    parameter int ROW_COUNT    = 6,
    parameter int COLUMN_COUNT = 18
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  kmd_pkg::in_item_t            s_item,
    output logic                         m_valid,
    input  logic                         m_ready,
    output kmd_pkg::out_item_t           m_item,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [kmd_pkg::RELOAD_W-1:0] cfg_data
);

    logic                         in_valid_reg;
    kmd_pkg::in_item_t            in_item_reg;
    logic                         out_valid_reg;
    kmd_pkg::out_item_t           out_item_reg;
    logic [kmd_pkg::RELOAD_W-1:0] reload_reg;
    logic                         advance;
    kmd_pkg::out_item_t           result;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;
    assign cfg_ready = 1'b1;

    kmd_state #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .reload  (reload_reg),
        .result  (result)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= kmd_pkg::RELOAD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            reload_reg <= cfg_data;
        end
    end

endmodule

// ===== design/kmd_state.sv =====
module kmd_state #(
    parameter int ROW_COUNT    = 6,
    parameter int COLUMN_COUNT = 18
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_en,
    input  kmd_pkg::in_item_t              item,
    input  logic [kmd_pkg::RELOAD_W-1:0]   reload,
    output kmd_pkg::out_item_t             result
);

    localparam int IDX_W   = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int COUNT_W = $clog2(ROW_COUNT * COLUMN_COUNT + 1);

    logic [ROW_COUNT-1:0] raw_reg     [COLUMN_COUNT];
    logic [ROW_COUNT-1:0] raw_next    [COLUMN_COUNT];
    logic [ROW_COUNT-1:0] stable_reg  [COLUMN_COUNT];
    logic [ROW_COUNT-1:0] stable_next [COLUMN_COUNT];

    logic [COUNT_W-1:0] raw_count_reg, raw_count_next;
    logic [COUNT_W-1:0] stable_count_reg, stable_count_next;
    logic [kmd_pkg::RELOAD_W-1:0] debounce_count_reg, debounce_count_next;

    logic                         col_ok;
    logic [IDX_W-1:0]             idx;
    logic [7:0]                   rows_ext;
    logic [ROW_COUNT-1:0]         rows;
    logic [ROW_COUNT-1:0]         raw_col;
    logic                         changed;
    logic [kmd_pkg::RELOAD_W-1:0] count_loaded;
    logic                         differ;
    logic                         commit;
    logic [ROW_COUNT-1:0]         stable_col;
    logic [7:0]                   stable_col_ext;
    logic [8:0]                   total;

    function automatic logic [COUNT_W-1:0] ones_in(input logic [ROW_COUNT-1:0] v);
        logic [COUNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < ROW_COUNT; i++) begin
            n = n + COUNT_W'(v[i]);
        end
        return n;
    endfunction

    always_comb begin
        col_ok   = {1'b0, item.column} < 6'(COLUMN_COUNT);
        idx      = item.column[IDX_W-1:0];
        rows_ext = 8'(item.row_bits);
        rows     = rows_ext[ROW_COUNT-1:0];
        raw_col  = col_ok ? raw_reg[idx] : '0;
        changed  = col_ok && (raw_col != rows);

        raw_next = raw_reg;
        if (changed) begin
            raw_next[idx] = rows;
        end
        raw_count_next = changed ? (raw_count_reg - ones_in(raw_col) + ones_in(rows))
                                 : raw_count_reg;

        count_loaded = changed ? reload : debounce_count_reg;

        differ = 1'b0;
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            differ = differ | (raw_next[c] != stable_reg[c]);
        end

        if (item.scan_end && (count_loaded != '0)) begin
            debounce_count_next = count_loaded - 8'd1;
        end else begin
            debounce_count_next = count_loaded;
        end

        commit = item.scan_end && (debounce_count_next == '0)
                 && ((count_loaded == 8'd1) || (reload == '0) || differ);

        stable_next       = commit ? raw_next : stable_reg;
        stable_count_next = commit ? raw_count_next : stable_count_reg;

        stable_col     = col_ok ? stable_next[idx] : '0;
        stable_col_ext = 8'(stable_col);
        total          = 9'(stable_count_next);

        result.column_state = stable_col_ext[kmd_pkg::ROW_BITS_W-1:0];
        result.settled      = (debounce_count_next == '0);
        result.committed    = commit;
        result.bounce       = changed && (debounce_count_reg != '0);
        result.key_count    = (total > 9'(kmd_pkg::KEY_COUNT_MAX)) ? kmd_pkg::KEY_COUNT_MAX
                                                                  : total[6:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < COLUMN_COUNT; c++) begin
                raw_reg[c]    <= '0;
                stable_reg[c] <= '0;
            end
            raw_count_reg      <= '0;
            stable_count_reg   <= '0;
            debounce_count_reg <= kmd_pkg::RELOAD_RESET;
        end else if (step_en) begin
            raw_reg            <= raw_next;
            stable_reg         <= stable_next;
            raw_count_reg      <= raw_count_next;
            stable_count_reg   <= stable_count_next;
            debounce_count_reg <= debounce_count_next;
        end
    end

endmodule
